@@ rtl/core/stbs_pkg.sv @@
// Shared types, constants and sequencer microcode for the sorted-table search block.
`timescale 1ns / 1ps
package stbs_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned POS_W = 11;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_ISSUE = 2'd1,
    S_PROBE = 2'd2,
    S_EMIT  = 2'd3
  } step_e;

  typedef enum logic [1:0] {
    C_SEARCH = 2'd0,
    C_EMPTY  = 2'd1,
    C_FINISH = 2'd2,
    C_SLOT   = 2'd3
  } cond_e;

  typedef struct packed {
    logic  take;
    logic  init;
    logic  issue;
    logic  probe;
    logic  emit;
    cond_e cond;
    step_e target;
    step_e alt;
  } ctrl_t;

  localparam int unsigned NUM_STEPS = 4;

  localparam ctrl_t UCODE [NUM_STEPS] = '{
    '{take: 1'b1, init: 1'b1, issue: 1'b0, probe: 1'b0, emit: 1'b0,
      cond: C_SEARCH, target: S_ISSUE, alt: S_IDLE},
    '{take: 1'b0, init: 1'b0, issue: 1'b1, probe: 1'b0, emit: 1'b0,
      cond: C_EMPTY, target: S_EMIT, alt: S_PROBE},
    '{take: 1'b0, init: 1'b0, issue: 1'b0, probe: 1'b1, emit: 1'b0,
      cond: C_FINISH, target: S_EMIT, alt: S_PROBE},
    '{take: 1'b0, init: 1'b0, issue: 1'b0, probe: 1'b0, emit: 1'b1,
      cond: C_SLOT, target: S_IDLE, alt: S_EMIT}
  };

endpackage

@@ rtl/core/stbs_if.sv @@
// Request and response channel interfaces for the sorted-table search block.
`timescale 1ns / 1ps
interface stbs_req_if import stbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] load_index;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, output operation, output load_index, output key_value,
                  input ready);
  modport sink   (input valid, input operation, input load_index, input key_value,
                  output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

@@ rtl/core/stbs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sorted_table_binary_search.sv @@
// Top level: microcoded binary search over a software-loaded sorted key table.
//
//  channel  dir  handshake         payload
//  req_i    in   valid/ready       operation, load_index, key_value
//  rsp_o    out  valid/ready       found, position
//  cfg      in   cfg_we_i only     cfg_wdata_i -> entry_count
//
// A load word is written to the table as it is taken. A search makes at
// most ceil(log2(entry_count+1)) probes, one probe per cycle through the
// single table read port.
// Reset clears control only; the table is undefined until loaded.
// A stalled response sits in the output register; the next word is taken
// once that search result has been handed to the output register.
`timescale 1ns / 1ps
module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  stbs_req_if.sink          req_i,
  stbs_rsp_if.source        rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW:0] s;
    s = {1'b0, lo} + {1'b0, hi} - {{CW{1'b0}}, 1'b1};
    return AW'(s >> 1);
  endfunction

  step_e            step_q, step_d;
  ctrl_t            word;
  logic [CNT_W-1:0] cnt_q;
  logic [CW-1:0]    cnt_sat;
  logic [KEY_W-1:0] key_q;
  logic [CW-1:0]    low_q, high_q, nlow, nhigh, mid_inc;
  logic [AW-1:0]    mid_q;
  logic             found_q;
  logic [POS_W-1:0] pos_q;
  logic             out_valid_q, out_found_q;
  logic [POS_W-1:0] out_pos_q;

  logic             acc, acc_search, in_range, ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic             win_empty, eq, gt, probe_done, slot_free, cond_true;

  assign word = UCODE[step_q];

  always_comb begin
    acc        = req_i.valid & req_i.ready;
    acc_search = acc & (req_i.operation == OP_SEARCH);
    in_range   = 32'(req_i.load_index) < 32'(TABLE_DEPTH);
    ram_we     = acc & (req_i.operation == OP_LOAD) & in_range;
    cnt_sat    = (32'(cnt_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_q);
    win_empty  = !(low_q < high_q);
    eq         = ram_rdata == key_q;
    gt         = $signed(ram_rdata) > $signed(key_q);
    mid_inc    = CW'(mid_q) + CW'(1);
    nlow       = gt ? low_q : mid_inc;
    nhigh      = gt ? CW'(mid_q) : high_q;
    probe_done = eq | !(nlow < nhigh);
    slot_free  = !out_valid_q | rsp_o.ready;
    ram_re     = 1'b0;
    ram_raddr  = mid_of(low_q, high_q);
    if (word.issue) begin
      ram_re = !win_empty;
    end else if (word.probe) begin
      ram_re    = !probe_done;
      ram_raddr = mid_of(nlow, nhigh);
    end
    case (word.cond)
      C_SEARCH: cond_true = acc_search;
      C_EMPTY:  cond_true = win_empty;
      C_FINISH: cond_true = probe_done;
      C_SLOT:   cond_true = slot_free;
      default:  cond_true = 1'b0;
    endcase
    step_d = cond_true ? word.target : word.alt;
  end

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(req_i.load_index)),
    .wdata_i (req_i.key_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (word.emit && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (word.init && acc_search) begin
      key_q   <= req_i.key_value;
      low_q   <= '0;
      high_q  <= cnt_sat;
      found_q <= 1'b0;
      pos_q   <= '0;
    end
    if (word.probe) begin
      if (eq) begin
        found_q <= 1'b1;
        pos_q   <= POS_W'(mid_inc);
      end else begin
        low_q  <= nlow;
        high_q <= nhigh;
      end
    end
    if (ram_re) begin
      mid_q <= ram_raddr;
    end
    if (word.emit && slot_free) begin
      out_found_q <= found_q;
      out_pos_q   <= pos_q;
    end
  end

  assign req_i.ready    = word.take;
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.position = out_pos_q;

`ifndef SYNTHESIS
  a_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_PROBE) |-> ((CW'(mid_q) >= low_q) && (CW'(mid_q) < high_q)))
    else $error("probe index outside search window");

  a_high_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_ISSUE) |-> (high_q <= CW'(TABLE_DEPTH)))
    else $error("search window exceeds table depth");

  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.found) |-> (rsp_o.position == '0))
    else $error("miss reported with nonzero position");

  a_emit_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q == S_EMIT))
    else $error("response raised outside emit step");
`endif

endmodule
